@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks for simulation; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Check that a trigger implies a condition in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed: implication does not hold");

// Check that a trigger implies a condition in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, trig, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond)

`endif

`endif

@@ design/hcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree decoder package
// Node entry layout, request codes, sequencer states and shared structs.
// ----------------------------------------------------------------------------
package hcd_pkg;

    // Field widths
    localparam int IDX_W = 9;
    localparam int SYM_W = 8;

    // Default node table depth
    localparam int NODE_COUNT_DEF = 512;

    // One node table entry: leaf flag, symbol, left child, right child
    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } t_node;

    // Request codes
    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_DECODE = 1'b1
    } t_req_type;

    // Walk sequencer states
    typedef enum logic [1:0] {
        WS_IDLE,
        WS_ROOT,
        WS_CHILD
    } t_walk_state;

    // Result handed to the output register
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
    } t_result;

    // Sequencer status
    typedef struct packed {
        logic idle;
        logic at_root;
    } t_walk_status;

endpackage

@@ design/hcd_node_ram.sv @@
// ----------------------------------------------------------------------------
// Node table memory
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module hcd_node_ram #(
    parameter int DEPTH  = hcd_pkg::NODE_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  hcd_pkg::t_node      i_wr_data,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output hcd_pkg::t_node      o_rd_data
);
    import hcd_pkg::*;

    t_node r_mem [DEPTH];
    t_node r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/hcd_walk_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tree walk sequencer
// Issues node table reads and writes, evaluates each fetched node and
// tracks the walk. The current inner node is kept as its cached entry.
// ----------------------------------------------------------------------------
module hcd_walk_ctrl #(
    parameter int NODE_COUNT = hcd_pkg::NODE_COUNT_DEF,
    parameter int ADDR_W     = $clog2(NODE_COUNT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input item
    input  logic                        i_accept,
    input  logic                        i_req_type,
    input  logic [hcd_pkg::IDX_W-1:0]   i_node_index,
    input  logic [hcd_pkg::IDX_W-1:0]   i_left_child,
    input  logic [hcd_pkg::IDX_W-1:0]   i_right_child,
    input  logic                        i_leaf_flag,
    input  logic [hcd_pkg::SYM_W-1:0]   i_leaf_symbol,
    input  logic                        i_code_bit,
    input  logic [hcd_pkg::IDX_W-1:0]   i_root_index,
    // Output slot
    input  logic                        i_out_free,
    output hcd_pkg::t_result            o_result,
    output hcd_pkg::t_walk_status       o_status,
    // Node table
    output logic                        o_wr_en,
    output logic [ADDR_W-1:0]           o_wr_addr,
    output hcd_pkg::t_node              o_wr_data,
    output logic                        o_rd_en,
    output logic [ADDR_W-1:0]           o_rd_addr,
    input  hcd_pkg::t_node              i_rd_data
);
    import hcd_pkg::*;

    t_walk_state r_state, n_state;
    logic        r_at_root, n_at_root;
    t_node       r_cur, n_cur;
    logic        r_bit;
    logic        r_rd_zero;

    t_node            w_entry;
    t_node            w_eval;
    logic             w_bit;
    logic [IDX_W-1:0] w_child;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_load;
    logic             w_decode;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(NODE_COUNT);
    endfunction

    assign w_load   = i_accept && (t_req_type'(i_req_type) == REQ_LOAD);
    assign w_decode = i_accept && (t_req_type'(i_req_type) == REQ_DECODE);

    // Fetched entry; an index beyond the table reads as the all-zero node
    assign w_entry = r_rd_zero ? t_node'('0) : i_rd_data;

    // Node under evaluation: cached inner node when idle, fetched otherwise
    assign w_eval  = (r_state == WS_IDLE) ? r_cur : w_entry;
    assign w_bit   = (r_state == WS_IDLE) ? i_code_bit : r_bit;
    assign w_child = w_bit ? w_eval.right : w_eval.left;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            WS_IDLE: begin
                if (w_decode) begin
                    n_state = r_at_root ? WS_ROOT : WS_CHILD;
                end
            end
            WS_ROOT: begin
                if (w_entry.leaf) begin
                    n_state = i_out_free ? WS_IDLE : WS_ROOT;
                end else begin
                    n_state = WS_CHILD;
                end
            end
            WS_CHILD: begin
                if (w_entry.leaf) begin
                    n_state = i_out_free ? WS_IDLE : WS_CHILD;
                end else begin
                    n_state = WS_IDLE;
                end
            end
            default: n_state = WS_IDLE;
        endcase
    end

    // Outputs: table accesses and result
    always_comb begin
        o_rd_en          = 1'b0;
        w_rd_idx         = w_child;
        o_result.valid   = 1'b0;
        o_result.symbol  = w_eval.symbol;
        n_at_root        = r_at_root;
        n_cur            = r_cur;
        case (r_state)
            WS_IDLE: begin
                if (w_decode) begin
                    o_rd_en  = 1'b1;
                    w_rd_idx = r_at_root ? i_root_index : w_child;
                end
                if (w_load) begin
                    n_at_root = 1'b1;
                end
            end
            WS_ROOT: begin
                if (w_entry.leaf) begin
                    o_result.valid = i_out_free;
                    n_at_root      = 1'b1;
                end else begin
                    o_rd_en = 1'b1;
                end
            end
            WS_CHILD: begin
                if (w_entry.leaf) begin
                    o_result.valid = i_out_free;
                    n_at_root      = 1'b1;
                end else begin
                    n_cur     = w_entry;
                    n_at_root = 1'b0;
                end
            end
            default: begin
                o_rd_en = 1'b0;
            end
        endcase
    end

    assign o_rd_addr = ADDR_W'(w_rd_idx);

    // Node write straight from the accepted load item
    assign o_wr_en          = w_load && idx_in_range(i_node_index);
    assign o_wr_addr        = ADDR_W'(i_node_index);
    assign o_wr_data.leaf   = i_leaf_flag;
    assign o_wr_data.symbol = i_leaf_symbol;
    assign o_wr_data.left   = i_left_child;
    assign o_wr_data.right  = i_right_child;

    assign o_status.idle    = (r_state == WS_IDLE);
    assign o_status.at_root = r_at_root;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= WS_IDLE;
            r_at_root <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_at_root <= n_at_root;
        end
    end

    // Walk payload: cached node, code bit, out-of-range read mark
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (w_decode) begin
            r_bit <= i_code_bit;
        end
        if (o_rd_en) begin
            r_rd_zero <= !idx_in_range(w_rd_idx);
        end
    end

endmodule

@@ design/huffman_tree_bit_decoder.sv @@
// A load item (req_type 0) writes one node table entry and returns the walk to
// the root. A decode item (req_type 1) takes one code bit. The node table has a
// single read port with a registered read, so each decode step waits for one
// node fetch, and a step from a root that is an inner node waits for two: the
// root, then the child that the bit selects. A decoded symbol sits in the
// output register while the next item is accepted; the block stalls only when
// a new symbol is ready and the previous one has not been taken. Write
// root_index only while the block is idle; a new root takes effect when the
// next walk starts.
// ----------------------------------------------------------------------------
// Huffman tree bit decoder
// Walks a code tree held in a node table, one code bit per decode item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_tree_bit_decoder #(
    parameter int NODE_COUNT = hcd_pkg::NODE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration
    input  logic                        i_cfg_wr_en,
    input  logic [hcd_pkg::IDX_W-1:0]   i_cfg_wr_data,
    // Input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_req_type,
    input  logic [hcd_pkg::IDX_W-1:0]   i_node_index,
    input  logic [hcd_pkg::IDX_W-1:0]   i_left_child,
    input  logic [hcd_pkg::IDX_W-1:0]   i_right_child,
    input  logic                        i_leaf_flag,
    input  logic [hcd_pkg::SYM_W-1:0]   i_leaf_symbol,
    input  logic                        i_code_bit,
    // Output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcd_pkg::SYM_W-1:0]   o_symbol
);
    import hcd_pkg::*;

    localparam int ADDR_W = $clog2(NODE_COUNT);

    logic [IDX_W-1:0] r_root;
    logic             r_out_valid, n_out_valid;
    logic [SYM_W-1:0] r_out_symbol;

    logic              w_accept;
    logic              w_out_free;
    t_result           w_result;
    t_walk_status      w_status;
    logic              w_home;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    t_node             w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    t_node             w_rd_data;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = w_status.idle;

    hcd_walk_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_walk_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_req_type    (i_req_type),
        .i_node_index  (i_node_index),
        .i_left_child  (i_left_child),
        .i_right_child (i_right_child),
        .i_leaf_flag   (i_leaf_flag),
        .i_leaf_symbol (i_leaf_symbol),
        .i_code_bit    (i_code_bit),
        .i_root_index  (r_root),
        .i_out_free    (w_out_free),
        .o_result      (w_result),
        .o_status      (w_status),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data)
    );

    hcd_node_ram #(
        .DEPTH  (NODE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: load on a new result, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_result.valid) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_root <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_out_symbol <= w_result.symbol;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_out_symbol;

    // Walk parked at the root and ready for the next item
    assign w_home = w_status.idle && w_status.at_root;

    // Checks
    `ASSERT_IMPLIES(a_result_slot_free, i_clk, i_rst_n, w_result.valid, w_out_free)
    `ASSERT_NEXT(a_result_then_idle, i_clk, i_rst_n, w_result.valid, w_home && !w_result.valid)
    `ASSERT_NEXT(a_load_to_root, i_clk, i_rst_n, w_accept && !i_req_type, w_home)
    `ASSERT_IMPLIES(a_access_excl, i_clk, i_rst_n, w_wr_en, !w_rd_en && w_status.idle)

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman tree bit decoder testbench
// Loads code trees into the node table and streams code bits through them.
// The walk is tracked alongside the block, and each decoded symbol is checked
// in order. Only entries that have been written are ever reached.
// ----------------------------------------------------------------------------
module tb_top;
    import hcd_pkg::*;

    localparam int LIMIT     = 400000;
    localparam int QUIET_LO  = 1500;
    localparam int QUIET_HI  = 3500;
    localparam int ITEM_GOAL = 1750;
    localparam int SETTLE    = 8;

    typedef struct packed {
        t_req_type        kind;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             leaf_flag;
        logic [SYM_W-1:0] leaf_symbol;
        logic             code_bit;
    } t_tree_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_wr_data = '0;
    logic src_valid = 1'b0;
    t_tree_req src_item = '0;
    logic sink_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    logic [SYM_W-1:0] o_symbol;

    // Requests waiting to be driven and symbols still owed by the block
    t_tree_req pending_reqs[$];
    logic [SYM_W-1:0] symbols_due[$];

    // Decoder state tracked alongside the block
    t_node tree_mem [0:NODE_COUNT_DEF-1];
    logic [IDX_W-1:0] walk_pos = '0;
    logic walk_at_root = 1'b1;
    logic [IDX_W-1:0] root_sel = '0;

    // Stimulus bookkeeping: which entries hold a node
    bit gen_written [0:NODE_COUNT_DEF-1];
    int gen_list[$];
    bit tree_used [0:NODE_COUNT_DEF-1];
    int items_queued = 0;

    int cycle_count = 0;
    int err_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    huffman_tree_bit_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (src_valid),
        .o_ready       (o_ready),
        .i_req_type    (src_item.kind),
        .i_node_index  (src_item.node_index),
        .i_left_child  (src_item.left_child),
        .i_right_child (src_item.right_child),
        .i_leaf_flag   (src_item.leaf_flag),
        .i_leaf_symbol (src_item.leaf_symbol),
        .i_code_bit    (src_item.code_bit),
        .o_valid       (o_valid),
        .i_ready       (sink_ready),
        .o_symbol      (o_symbol)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random idle, suppressed inside the quiet window
    function automatic bit idle_roll();
        return (cycle_count < QUIET_LO || cycle_count > QUIET_HI)
            && ($urandom_range(0, 99) < 6);
    endfunction

    // Apply one accepted request to the tracked state, queue any symbol
    task automatic walk_tree(input t_tree_req req);
        t_node start;
        t_node nxt;
        t_node wr;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nidx;
        if (req.kind == REQ_LOAD) begin
            wr.leaf   = req.leaf_flag;
            wr.symbol = req.leaf_symbol;
            wr.left   = req.left_child;
            wr.right  = req.right_child;
            tree_mem[req.node_index] = wr;
            walk_at_root = 1'b1;
        end else begin
            cur = walk_at_root ? root_sel : walk_pos;
            start = tree_mem[cur];
            if (start.leaf) begin
                symbols_due.push_back(start.symbol);
                walk_at_root = 1'b1;
            end else begin
                nidx = req.code_bit ? start.right : start.left;
                nxt = tree_mem[nidx];
                if (nxt.leaf) begin
                    symbols_due.push_back(nxt.symbol);
                    walk_at_root = 1'b1;
                end else begin
                    walk_pos = nidx;
                    walk_at_root = 1'b0;
                end
            end
        end
    endtask

    task automatic push_load(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] lc,
                             input logic [IDX_W-1:0] rc, input logic leaf,
                             input logic [SYM_W-1:0] sym);
        t_tree_req req;
        req.kind        = REQ_LOAD;
        req.node_index  = idx;
        req.left_child  = lc;
        req.right_child = rc;
        req.leaf_flag   = leaf;
        req.leaf_symbol = sym;
        req.code_bit    = 1'($urandom_range(0, 1));
        pending_reqs.push_back(req);
        items_queued++;
        if (!gen_written[idx]) begin
            gen_written[idx] = 1'b1;
            gen_list.push_back(int'(idx));
        end
    endtask

    // Node write fields carry noise on a decode
    task automatic push_decode(input logic b);
        t_tree_req req;
        req.kind        = REQ_DECODE;
        req.node_index  = IDX_W'($urandom);
        req.left_child  = IDX_W'($urandom);
        req.right_child = IDX_W'($urandom);
        req.leaf_flag   = 1'($urandom_range(0, 1));
        req.leaf_symbol = SYM_W'($urandom);
        req.code_bit    = b;
        pending_reqs.push_back(req);
        items_queued++;
    endtask

    function automatic logic [IDX_W-1:0] pick_written();
        return IDX_W'(gen_list[$urandom_range(0, gen_list.size() - 1)]);
    endfunction

    function automatic logic [IDX_W-1:0] fresh_index();
        int idx;
        do idx = $urandom_range(0, NODE_COUNT_DEF - 1); while (tree_used[idx]);
        tree_used[idx] = 1'b1;
        return IDX_W'(idx);
    endfunction

    // Leaves first, then inner nodes bottom-up, the root entry last
    task automatic build_tree(input logic [IDX_W-1:0] root, input int nleaves);
        int forest[$];
        int k;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] idx;
        foreach (tree_used[i]) tree_used[i] = 1'b0;
        tree_used[root] = 1'b1;
        if (nleaves == 1) begin
            push_load(root, IDX_W'($urandom), IDX_W'($urandom), 1'b1, SYM_W'($urandom));
        end else begin
            for (k = 0; k < nleaves; k++) begin
                idx = fresh_index();
                push_load(idx, IDX_W'($urandom), IDX_W'($urandom), 1'b1, SYM_W'($urandom));
                forest.push_back(int'(idx));
            end
            while (forest.size() > 2) begin
                k = $urandom_range(0, forest.size() - 1);
                a = IDX_W'(forest[k]);
                forest.delete(k);
                k = $urandom_range(0, forest.size() - 1);
                b = IDX_W'(forest[k]);
                forest.delete(k);
                idx = fresh_index();
                push_load(idx, a, b, 1'b0, SYM_W'($urandom));
                forest.push_back(int'(idx));
            end
            push_load(root, IDX_W'(forest[0]), IDX_W'(forest[1]), 1'b0, SYM_W'($urandom));
        end
    endtask

    // Overwrite any entry; inner nodes only point at written entries
    task automatic noise_load();
        logic [IDX_W-1:0] idx;
        idx = IDX_W'($urandom_range(0, NODE_COUNT_DEF - 1));
        if ($urandom_range(0, 1))
            push_load(idx, IDX_W'($urandom), IDX_W'($urandom), 1'b1, SYM_W'($urandom));
        else
            push_load(idx, pick_written(), pick_written(), 1'b0, SYM_W'($urandom));
    endtask

    task automatic decode_run(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 5)
                noise_load();
            else
                push_decode(1'($urandom_range(0, 1)));
        end
    endtask

    // Hold the sender until the block has drained and stayed quiet
    task automatic settle();
        int quiet;
        quiet = 0;
        while (quiet < SETTLE) begin
            @(posedge i_clk);
            if (pending_reqs.size() != 0 || src_valid || symbols_due.size() != 0 || o_valid)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic set_root(input logic [IDX_W-1:0] r);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= r;
        root_sel = r;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    // Stimulus
    initial begin
        int r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Two leaves under the top index, extreme symbols
        set_root(9'd511);
        push_load(9'd0, 9'd511, 9'd0, 1'b1, 8'h00);
        push_load(9'd1, 9'd0, 9'd511, 1'b1, 8'hFF);
        push_load(9'd511, 9'd0, 9'd1, 1'b0, 8'hA5);
        push_decode(1'b0);
        push_decode(1'b1);
        // Deeper tree, a load restarting the walk, leave the walk mid-tree
        push_load(9'd2, 9'd0, 9'd1, 1'b0, 8'h5A);
        push_load(9'd511, 9'd2, 9'd1, 1'b0, 8'h3C);
        push_decode(1'b0);
        push_decode(1'b1);
        push_decode(1'b0);
        push_load(9'd3, 9'd3, 9'd3, 1'b0, 8'h81);
        push_decode(1'b1);
        push_decode(1'b0);
        // Root moves while the walk is in progress
        set_root(9'd1);
        push_decode(1'b0);
        push_decode(1'b1);
        push_decode(1'b0);
        // Root that is itself a leaf
        set_root(9'd0);
        push_decode(1'b1);
        push_decode(1'b0);
        // Root that loops back on itself
        set_root(9'd3);
        push_decode(1'b0);
        push_decode(1'b1);

        // Random phases: fresh trees, or re-rooting onto existing entries
        while (items_queued < ITEM_GOAL) begin
            if ($urandom_range(0, 9) < 2) begin
                set_root(pick_written());
                decode_run($urandom_range(20, 40));
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        r = 0;
                    end
                    1: begin
                        r = NODE_COUNT_DEF - 1;
                    end
                    default: begin
                        r = $urandom_range(0, NODE_COUNT_DEF - 1);
                    end
                endcase
                set_root(IDX_W'(r));
                build_tree(IDX_W'(r), ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12));
                decode_run($urandom_range(40, 100));
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Driver: advance the request queue, track each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && o_ready)
                walk_tree(src_item);
            if (!src_valid || o_ready) begin
                if (pending_reqs.size() != 0 && !idle_roll()) begin
                    src_item <= pending_reqs.pop_front();
                    src_valid <= 1'b1;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each symbol transfer against the oldest one owed
    always @(posedge i_clk) begin
        logic [SYM_W-1:0] want;
        if (i_rst_n && o_valid && sink_ready) begin
            if (symbols_due.size() == 0) begin
                note_error($sformatf("unexpected symbol %02h", o_symbol));
            end else begin
                want = symbols_due.pop_front();
                if (o_symbol !== want)
                    note_error($sformatf("symbol mismatch: expected %02h, got %02h",
                                         want, o_symbol));
            end
            results_seen++;
        end
        // Hold off once for a long stretch so the block backs up
        if (hold_left > 0) begin
            hold_left--;
        end else if (results_seen >= 100 && !hold_done) begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        sink_ready <= (hold_left == 0) && !idle_roll();
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule
